/* hw/rtl/ptf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptf_pkg: shared types and constants of the top-percent threshold filter
// Job descriptor handed from the loader to the select engine, result bundle,
// and the fixed constants of the keep-count arithmetic.
// ----------------------------------------------------------------------------
package ptf_pkg;

  localparam int MAX_ELEMS_DEF  = 64;
  localparam int VALUE_BITS_DEF = 32;

  // Element count (up to 64) and percent both fit in seven bits.
  localparam int CNT_W = 7;
  localparam int PCT_W = 7;

  localparam logic [PCT_W-1:0] PCT_RESET = 7'd100;
  localparam logic [PCT_W-1:0] PCT_MAX   = 7'd100;

  // ceil(x / 100) is floor((x + 99) / 100); the divide by 100 is done as a
  // multiply by 5243 / 2^19, which is exact for sums below 6500.
  localparam int ROUND_UP    = 99;
  localparam int RECIP       = 5243;
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 19;

  localparam int IDX_OUT_W = 6;
  localparam int VAL_OUT_W = 32;

  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [PCT_W-1:0] pct;
  } job_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] elem_index;
    logic [VAL_OUT_W-1:0] elem_value;
    logic                 run_end;
    logic                 none_kept;
  } result_t;

endpackage : ptf_pkg
`default_nettype wire

/* hw/rtl/ptf_job_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptf_job_fifo: two-entry job queue
// Holds closed-set descriptors between the loader and the select engine.
// ----------------------------------------------------------------------------
module ptf_job_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ptf_pkg::job_t push_job,
  input  logic          pop,
  output ptf_pkg::job_t head_job,
  output logic          empty
);
  import ptf_pkg::*;

  job_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign empty    = (count == 2'd0);
  assign head_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule : ptf_job_fifo
`default_nettype wire

/* hw/rtl/ptf_loader.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptf_loader: front end of the filter
// Accepts items, writes values into the engine's store, drops items once the
// store is full, and turns a flagged item into a job for the engine.
// ----------------------------------------------------------------------------
module ptf_loader #(
  parameter int MAX_ELEMS  = ptf_pkg::MAX_ELEMS_DEF,
  parameter int VALUE_BITS = ptf_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  logic signed [31:0]           sample_value,
  input  logic                         final_item,
  input  logic                         cfg_we,
  input  logic [ptf_pkg::PCT_W-1:0]    cfg_wdata,
  output logic                         wr_en,
  output logic [$clog2(MAX_ELEMS)-1:0] wr_addr,
  output logic [VALUE_BITS-1:0]        wr_data,
  output logic                         push,
  output ptf_pkg::job_t                push_job
);
  import ptf_pkg::*;

  localparam int CW = $clog2(MAX_ELEMS + 1);
  localparam int IW = $clog2(MAX_ELEMS);

  logic [PCT_W-1:0]       keep_percent;
  logic [CW-1:0]          loaded_count;
  logic [CW-1:0]          n_close;
  logic                   accept;
  logic                   store_full;
  logic [VALUE_BITS+31:0] in_ext;

  assign accept     = start && !busy;
  assign store_full = (loaded_count == CW'(MAX_ELEMS));
  assign n_close    = store_full ? loaded_count : loaded_count + CW'(1);

  assign in_ext  = {{VALUE_BITS{1'b0}}, sample_value};
  assign wr_en   = accept && !store_full;
  assign wr_addr = loaded_count[IW-1:0];
  assign wr_data = in_ext[VALUE_BITS-1:0];

  assign push         = accept && final_item;
  assign push_job.n   = CNT_W'(n_close);
  assign push_job.pct = (keep_percent > PCT_MAX) ? PCT_MAX : keep_percent;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_percent <= PCT_RESET;
      loaded_count <= '0;
    end else begin
      if (cfg_we) begin
        keep_percent <= cfg_wdata;
      end
      if (push) begin
        loaded_count <= '0;
      end else if (wr_en) begin
        loaded_count <= loaded_count + CW'(1);
      end
    end
  end

endmodule : ptf_loader
`default_nettype wire

/* hw/rtl/ptf_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptf_engine: back end of the filter
// Owns the value store. For a job it computes the keep count, finds the
// threshold by counting, for each candidate, the elements at or above it,
// and then streams out every element at or above the threshold in order.
// ----------------------------------------------------------------------------
module ptf_engine #(
  parameter int MAX_ELEMS  = ptf_pkg::MAX_ELEMS_DEF,
  parameter int VALUE_BITS = ptf_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_ELEMS)-1:0] wr_addr,
  input  logic [VALUE_BITS-1:0]        wr_data,
  input  logic                         job_ready,
  input  ptf_pkg::job_t                job,
  output logic                         job_pop,
  output logic                         engine_busy,
  output logic                         res_strobe,
  output ptf_pkg::result_t             res
);
  import ptf_pkg::*;

  localparam int CW     = $clog2(MAX_ELEMS + 1);
  localparam int IW     = $clog2(MAX_ELEMS);
  localparam int MW     = CW + PCT_W + 1;
  localparam int PROD_W = $clog2(MAX_ELEMS * 100 + ROUND_UP + 1);
  localparam int QW     = PROD_W + RECIP_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_CAND,
    S_LOAD,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t state;

  logic [VALUE_BITS-1:0] store [MAX_ELEMS];
  logic [VALUE_BITS-1:0] rd_data;
  logic [IW-1:0]         rd_addr;

  logic [CW-1:0]         n;
  logic [PCT_W-1:0]      pct;
  logic [PROD_W-1:0]     prod;
  logic [CW-1:0]         rank;
  logic [CW-1:0]         cand;
  logic [CW-1:0]         scan_ptr;
  logic                  data_valid;
  logic [IW-1:0]         data_addr;
  logic [VALUE_BITS-1:0] cand_val;
  logic [CW-1:0]         ge_count;
  logic                  found;
  logic [VALUE_BITS-1:0] threshold;
  logic [CW-1:0]         keep_count;
  logic [CW-1:0]         emitted;

  logic [MW-1:0]         mul_full;
  logic [QW-1:0]         quot_full;
  logic [CW-1:0]         rank_calc;
  logic                  issue;
  logic                  scan_done;
  logic                  cand_hit;
  logic                  emit_hit;
  logic                  better;
  logic [CW-1:0]         cand_inc;
  logic [VALUE_BITS+31:0] out_ext;
  logic [IW+IDX_OUT_W-1:0] idx_ext;

  assign mul_full  = MW'(n) * MW'(pct) + MW'(ROUND_UP);
  assign quot_full = QW'(prod) * QW'(RECIP);
  assign rank_calc = CW'(quot_full >> RECIP_SHIFT);

  assign issue     = (scan_ptr < n);
  assign scan_done = !issue && !data_valid;
  assign cand_hit  = data_valid && ($signed(rd_data) >= $signed(cand_val));
  assign emit_hit  = data_valid && ($signed(rd_data) >= $signed(threshold));
  assign better    = (ge_count >= rank) && (!found || ($signed(cand_val) > $signed(threshold)));
  assign cand_inc  = cand + CW'(1);

  assign out_ext = {32'b0, rd_data};
  assign idx_ext = {{IDX_OUT_W{1'b0}}, data_addr};

  assign job_pop     = (state == S_IDLE) && job_ready;
  assign engine_busy = (state != S_IDLE);

  always_comb begin
    if (state == S_CAND) begin
      rd_addr = cand[IW-1:0];
    end else begin
      rd_addr = scan_ptr[IW-1:0];
    end
  end

  // Single-write, single-read store with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    rd_data <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      data_valid <= 1'b0;
      found      <= 1'b0;
      threshold  <= '0;
      res_strobe <= 1'b0;
    end else begin
      res_strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (job_ready) begin
            n     <= CW'(job.n);
            pct   <= job.pct;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= PROD_W'(mul_full);
          state <= S_DIV;
        end
        S_DIV: begin
          rank  <= rank_calc;
          found <= 1'b0;
          cand  <= '0;
          if (rank_calc == '0) begin
            res_strobe     <= 1'b1;
            res.elem_index <= '0;
            res.elem_value <= '0;
            res.run_end    <= 1'b1;
            res.none_kept  <= 1'b1;
            state          <= S_IDLE;
          end else begin
            state <= S_CAND;
          end
        end
        S_CAND: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          cand_val   <= rd_data;
          scan_ptr   <= '0;
          data_valid <= 1'b0;
          ge_count   <= '0;
          state      <= S_SCAN;
        end
        S_SCAN: begin
          data_valid <= issue;
          data_addr  <= scan_ptr[IW-1:0];
          if (issue) begin
            scan_ptr <= scan_ptr + CW'(1);
          end
          if (cand_hit) begin
            ge_count <= ge_count + CW'(1);
          end
          if (scan_done) begin
            // The threshold is the largest value with at least rank elements
            // at or above it.
            if (better) begin
              found      <= 1'b1;
              threshold  <= cand_val;
              keep_count <= ge_count;
            end
            cand <= cand_inc;
            if (cand_inc == n) begin
              scan_ptr   <= '0;
              data_valid <= 1'b0;
              emitted    <= '0;
              state      <= S_EMIT;
            end else begin
              state <= S_CAND;
            end
          end
        end
        S_EMIT: begin
          data_valid <= issue;
          data_addr  <= scan_ptr[IW-1:0];
          if (issue) begin
            scan_ptr <= scan_ptr + CW'(1);
          end
          if (emit_hit) begin
            res_strobe     <= 1'b1;
            res.elem_index <= idx_ext[IDX_OUT_W-1:0];
            res.elem_value <= out_ext[VAL_OUT_W-1:0];
            res.run_end    <= (emitted + CW'(1) == keep_count);
            res.none_kept  <= 1'b0;
            emitted        <= emitted + CW'(1);
          end
          if (scan_done) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule : ptf_engine
`default_nettype wire

/* hw/rtl/top_percent_threshold_filter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// top_percent_threshold_filter: keep the top percent of a loaded set
// Collects a set of signed Q16.16 values and emits, in load order, every
// element at or above the k-th largest value, k = ceil(n * percent / 100).
// ----------------------------------------------------------------------------
// Usage:
//   Input: an item (sample_value, final_item) is taken at a clock edge where
//   start is high and busy is low. Non-final items produce nothing. Items
//   beyond MAX_ELEMS are dropped; a flagged one still closes the set.
//   Closing a set raises busy. The engine then computes the keep count in
//   its multiply and divide states and selects the threshold with one pass
//   over the store per candidate, limited by the single read port of the
//   store; busy stays high until the engine has finished the job.
//   Results: one item per cycle when result_strobe is high, emitted during
//   the final pass; the last one carries run_end. With a percent of zero a
//   single item with none_kept and run_end is produced. There is no
//   backpressure on results; each is valid for exactly one cycle.
//   Configuration: cfg_we with cfg_wdata sets the keep percent (reset 100,
//   values above 100 act as 100). Write it only while the block is idle.
//   Reset clears the set in progress and the pending jobs.
// ----------------------------------------------------------------------------
module top_percent_threshold_filter #(
  parameter int MAX_ELEMS  = ptf_pkg::MAX_ELEMS_DEF,
  parameter int VALUE_BITS = ptf_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [31:0]                sample_value,
  input  logic                              final_item,
  input  logic                              cfg_we,
  input  logic [ptf_pkg::PCT_W-1:0]         cfg_wdata,
  output logic                              result_strobe,
  output logic [ptf_pkg::IDX_OUT_W-1:0]     elem_index,
  output logic signed [ptf_pkg::VAL_OUT_W-1:0] elem_value,
  output logic                              run_end,
  output logic                              none_kept
);
  import ptf_pkg::*;

  localparam int IW = $clog2(MAX_ELEMS);

  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [VALUE_BITS-1:0] wr_data;
  logic                  push;
  job_t                  push_job;
  job_t                  head_job;
  logic                  fifo_empty;
  logic                  job_pop;
  logic                  engine_busy;
  result_t               res;

  // The store is shared, so a new set waits until every queued job is done.
  assign busy = !fifo_empty || engine_busy;

  ptf_loader #(
    .MAX_ELEMS  (MAX_ELEMS),
    .VALUE_BITS (VALUE_BITS)
  ) u_loader (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .sample_value (sample_value),
    .final_item   (final_item),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .push         (push),
    .push_job     (push_job)
  );

  ptf_job_fifo u_job_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (job_pop),
    .head_job (head_job),
    .empty    (fifo_empty)
  );

  ptf_engine #(
    .MAX_ELEMS  (MAX_ELEMS),
    .VALUE_BITS (VALUE_BITS)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .job_ready   (!fifo_empty),
    .job         (head_job),
    .job_pop     (job_pop),
    .engine_busy (engine_busy),
    .res_strobe  (result_strobe),
    .res         (res)
  );

  assign elem_index = res.elem_index;
  assign elem_value = res.elem_value;
  assign run_end    = res.run_end;
  assign none_kept  = res.none_kept;

  // Closing a set always hands a job to the engine.
  a_close_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && final_item |=> busy)
    else $error("closing item did not make the block busy");

  // The last result of a set is never followed directly by another.
  a_end_gap: assert property (@(posedge clk) disable iff (rst)
    result_strobe && run_end |=> !result_strobe)
    else $error("result directly after the end of a set");

  // Results are produced only for a job the engine has taken.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(engine_busy))
    else $error("result without an active job");

endmodule : top_percent_threshold_filter
`default_nettype wire
